FILE: rtl/ptcs_pkg.sv
// shared types and constants for the periodic tick compare scheduler
// no dependencies
`default_nettype none

package ptcs_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_IRQ    = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    // reserved code, leaves the timer state unchanged
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int IN_BITS   = 165;
    localparam int IN_TDATA_W = 168;
    localparam int DIV_STEPS = 64;

    localparam logic [63:0] STOP_COMPARE = 64'h8000_0000_0000_0000;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [31:0] first_frac;
        logic [16:0] first_sec;
        logic        first_given;
        logic [31:0] period_frac;
        logic [16:0] period_sec;
        logic        period_given;
        logic [62:0] counter_now;
        logic [1:0]  op;
    } item_t;

    typedef enum logic [1:0] {
        MSEL_PF,
        MSEL_PS,
        MSEL_FF,
        MSEL_FS
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_P_HI,
        ACC_P_ADD,
        ACC_F_HI,
        ACC_F_ADD
    } acc_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_t     acc;
        logic     div_init;
        logic     div_step;
        logic     fin;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       start_zero;
        logic       run_zero;
        logic       out_busy;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/ptcs_ctrl.sv
// controller state machine sequencing multiply, divide and finish steps
// depends on ptcs_pkg
`default_nettype none

module ptcs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ptcs_pkg::status_t sts,
    output ptcs_pkg::cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_CHECK,
        S_DIV_INIT,
        S_DIV_RUN,
        S_FIN
    } state_t;

    state_t     state_reg;
    logic [5:0] cnt_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = ptcs_pkg::MSEL_PF;
        cmd.acc      = ptcs_pkg::ACC_NONE;
        unique case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ptcs_pkg::MSEL_PF;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ptcs_pkg::MSEL_PS;
                cmd.acc     = ptcs_pkg::ACC_P_HI;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ptcs_pkg::MSEL_FF;
                cmd.acc     = ptcs_pkg::ACC_P_ADD;
            end
            S_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ptcs_pkg::MSEL_FS;
                cmd.acc     = ptcs_pkg::ACC_F_HI;
            end
            S_MUL4:     cmd.acc = ptcs_pkg::ACC_F_ADD;
            S_DIV_INIT: cmd.div_init = 1'b1;
            S_DIV_RUN:  cmd.div_step = 1'b1;
            S_FIN:      cmd.fin = !sts.out_busy;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DECODE;
                S_DECODE:
                    if (sts.op == ptcs_pkg::OP_START)
                        state_reg <= S_MUL0;
                    else if (sts.op == ptcs_pkg::OP_IRQ && !sts.run_zero)
                        state_reg <= S_DIV_INIT;
                    else
                        state_reg <= S_FIN;
                S_MUL0:  state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_MUL3;
                S_MUL3:  state_reg <= S_MUL4;
                S_MUL4:  state_reg <= S_CHECK;
                S_CHECK: state_reg <= sts.start_zero ? S_FIN : S_DIV_INIT;
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_RUN;
                end
                S_DIV_RUN:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ptcs_pkg::DIV_STEPS - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                    if (!sts.out_busy)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ptcs_dp.sv
// datapath: shared multiplier, bit-serial divider, timer state and result register
// depends on ptcs_pkg
`default_nettype none

module ptcs_dp #(
    parameter int EVENT_COUNT_BITS = 16,
    parameter int OUT_W = 216
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ptcs_pkg::IN_TDATA_W-1:0] in_data,
    input  wire logic                      cfg_valid,
    input  wire logic [31:0]               cfg_data,
    input  wire ptcs_pkg::cmd_t            cmd,
    output ptcs_pkg::status_t              sts,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [OUT_W-1:0]               out_data
);

    localparam int E = EVENT_COUNT_BITS;

    ptcs_pkg::item_t item_reg;
    logic [31:0] freq_reg;
    logic [63:0] prod_reg;
    logic [63:0] pt_reg;
    logic [63:0] ft_reg;
    logic [63:0] period_reg;
    logic [63:0] early_reg;
    logic [63:0] ref_reg;
    logic [31:0] edges_reg;
    logic [31:0] excess_reg;
    logic [31:0] missed_reg;
    logic [31:0] adjusted_reg;
    logic [63:0] div_x_reg;
    logic [63:0] div_d_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic        neg_reg;
    logic        res_valid_reg;
    logic        cmp_valid_reg;
    logic [63:0] cmp_reg;
    logic [E-1:0] ev_reg;

    logic        cmp_valid_next;
    logic [63:0] cmp_next;
    logic [E-1:0] ev_next;

    logic [31:0] mul_b;
    logic [63:0] now64;
    logic [63:0] div_eff;
    logic [63:0] fdiv_eff;
    logic [63:0] delta;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic [E-1:0] ev_sat;

    assign now64    = {1'b0, item_reg.counter_now};
    assign div_eff  = item_reg.period_given ? pt_reg : 64'd0;
    assign fdiv_eff = item_reg.first_given ? ft_reg : div_eff;
    assign delta    = now64 - ref_reg;
    assign shifted  = {rem_reg, quo_reg[63]};
    assign diff     = shifted - {1'b0, div_d_reg};
    assign ev_sat   = (quo_reg[63:E] != '0) ? {E{1'b1}} : quo_reg[E-1:0];

    assign sts.op         = item_reg.op;
    assign sts.start_zero = (div_eff == 64'd0);
    assign sts.run_zero   = (period_reg == 64'd0);
    assign sts.out_busy   = res_valid_reg && !out_ready;

    assign out_valid = res_valid_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            ptcs_pkg::MSEL_PF: mul_b = item_reg.period_frac;
            ptcs_pkg::MSEL_PS: mul_b = {15'd0, item_reg.period_sec};
            ptcs_pkg::MSEL_FF: mul_b = item_reg.first_frac;
            ptcs_pkg::MSEL_FS: mul_b = {15'd0, item_reg.first_sec};
            default:           mul_b = '0;
        endcase
    end

    always_comb
    begin
        out_data = '0;
        out_data[192+E:0] = {adjusted_reg, missed_reg, excess_reg, edges_reg,
                             ev_reg, cmp_reg, cmp_valid_reg};
    end

    // result fields of the item being finished
    always_comb
    begin
        cmp_valid_next = 1'b0;
        cmp_next       = '0;
        ev_next        = '0;
        unique case (item_reg.op)
            ptcs_pkg::OP_START:
            begin
                cmp_valid_next = 1'b1;
                cmp_next = ((div_eff != 64'd0) ? (div_x_reg - rem_reg) : now64) + fdiv_eff;
            end
            ptcs_pkg::OP_IRQ:
            begin
                if (period_reg != 64'd0)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_next       = now64 + period_reg - early_reg;
                    ev_next        = ev_sat;
                end
                else
                    ev_next = E'(1);
            end
            ptcs_pkg::OP_STOP:
            begin
                cmp_valid_next = 1'b1;
                cmp_next       = ptcs_pkg::STOP_COMPARE;
            end
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= ptcs_pkg::item_t'(in_data[ptcs_pkg::IN_BITS-1:0]);
        if (cmd.mul_en)
            prod_reg <= 64'(freq_reg) * 64'(mul_b);
        unique case (cmd.acc)
            ptcs_pkg::ACC_P_HI:  pt_reg <= {32'd0, prod_reg[63:32]};
            ptcs_pkg::ACC_P_ADD: pt_reg <= pt_reg + prod_reg;
            ptcs_pkg::ACC_F_HI:  ft_reg <= {32'd0, prod_reg[63:32]};
            ptcs_pkg::ACC_F_ADD: ft_reg <= ft_reg + prod_reg;
            default:             ;
        endcase
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            if (item_reg.op == ptcs_pkg::OP_START)
            begin
                div_x_reg <= now64 + div_eff - 64'd1;
                quo_reg   <= now64 + div_eff - 64'd1;
                div_d_reg <= div_eff;
                neg_reg   <= 1'b0;
            end
            else
            begin
                quo_reg   <= delta[63] ? 64'd0 : delta;
                div_d_reg <= period_reg;
                neg_reg   <= delta[63];
            end
        end
        else if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.fin)
        begin
            cmp_valid_reg <= cmp_valid_next;
            cmp_reg       <= cmp_next;
            ev_reg        <= ev_next;
        end
    end

    // control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= 32'd1;
            period_reg    <= '0;
            early_reg     <= '0;
            ref_reg       <= '0;
            edges_reg     <= '0;
            excess_reg    <= '0;
            missed_reg    <= '0;
            adjusted_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                freq_reg <= cfg_data;
            if (cmd.fin)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && out_ready)
                res_valid_reg <= 1'b0;
            if (cmd.fin)
            begin
                unique case (item_reg.op)
                    ptcs_pkg::OP_START:
                    begin
                        period_reg <= div_eff;
                        if (div_eff != 64'd0)
                        begin
                            early_reg <= '0;
                            ref_reg   <= div_x_reg - rem_reg;
                        end
                        else
                            ref_reg <= now64;
                    end
                    ptcs_pkg::OP_IRQ:
                    begin
                        if (period_reg != 64'd0)
                        begin
                            if (!neg_reg)
                                ref_reg <= now64 - rem_reg;
                            if (early_reg != 64'd0)
                                adjusted_reg <= adjusted_reg + quo_reg[31:0];
                            if (quo_reg != 64'd0)
                            begin
                                missed_reg <= missed_reg + quo_reg[31:0] - 32'd1;
                                if (rem_reg > (period_reg >> 3))
                                begin
                                    if (early_reg == 64'd0)
                                        edges_reg <= edges_reg + 32'd1;
                                    early_reg <= period_reg >> 4;
                                end
                                else
                                    early_reg <= '0;
                            end
                            else
                            begin
                                early_reg  <= '0;
                                excess_reg <= excess_reg + 32'd1;
                            end
                        end
                    end
                    ptcs_pkg::OP_STOP: period_reg <= '0;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/periodic_tick_compare_scheduler.sv
// top level of the periodic tick compare scheduler
// depends on ptcs_pkg, ptcs_ctrl and ptcs_dp
`default_nettype none

// Event-timer compare scheduler. One item goes in, one result comes out, one item
// at a time. A start item converts period and first delay (seconds plus 32-bit
// binary fraction) into ticks with a 32x32 multiplier used four times, then
// rounds the counter up to a period multiple through a 64-step restoring
// divider. A one-shot start skips the divider. An interrupt item runs the
// divider alone to count elapsed periods. Stop items, unused ops and interrupts
// with no periodic timer go straight to the finish step. The divider yields one
// quotient bit per cycle. The result sits in an output register, so the next
// item is accepted while it waits; the block only stalls at the end of the next
// item if the result is still not taken. The user must write tick_frequency over
// cfg_* only while the block is idle; the block itself does not enforce it
// (cfg_ready is always high).

module periodic_tick_compare_scheduler #(
    parameter int EVENT_COUNT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,      // tick_frequency
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op, counter_now, period_given, period_sec, period_frac,
    // first_given, first_sec, first_frac
    input  wire logic [ptcs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // compare_valid, compare_value, event_count, edges_total,
    // excess_total, missed_total, adjusted_total
    output logic [((193+EVENT_COUNT_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W = ((193 + EVENT_COUNT_BITS + 7) / 8) * 8;

    ptcs_pkg::cmd_t    cmd;
    ptcs_pkg::status_t sts;

    // register writes are never stalled
    assign cfg_ready = 1'b1;

    ptcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptcs_dp #(
        .EVENT_COUNT_BITS (EVENT_COUNT_BITS),
        .OUT_W            (OUT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/ptcs_checker.sv
// port-level checks for the periodic tick compare scheduler
// depends on periodic_tick_compare_scheduler; bound to it below
`default_nettype none

module ptcs_checker #(
    parameter int EVENT_COUNT_BITS = 16,
    parameter int OUT_W = 216
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // no compare write means a zero compare value
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[64:1] == 64'd0)
        else $error("compare value without compare_valid");

    // without a compare write at most one event is delivered
    a_idle_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0]
        |-> m_axis_tdata[64+EVENT_COUNT_BITS:65] <= EVENT_COUNT_BITS'(1))
        else $error("several events without compare write");

endmodule

bind periodic_tick_compare_scheduler ptcs_checker #(
    .EVENT_COUNT_BITS (EVENT_COUNT_BITS),
    .OUT_W            (OUT_W)
) u_ptcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the periodic tick compare scheduler
// depends on ptcs_pkg and periodic_tick_compare_scheduler
`default_nettype none

module testbench;

    localparam int ECB = 16;
    localparam int OUT_W = ((193 + ECB + 7) / 8) * 8;
    localparam int LIMIT = 3000000;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [31:0]    adjusted_total;
        logic [31:0]    missed_total;
        logic [31:0]    excess_total;
        logic [31:0]    edges_total;
        logic [ECB-1:0] event_count;
        logic [63:0]    compare_value;
        logic           compare_valid;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [ptcs_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    // shadow copy of the scheduler state
    logic [31:0] freq_model;
    logic [63:0] period_model, adjust_model, ref_model;
    logic [31:0] edges_model, excess_model, missed_model, adjusted_model;

    ptcs_pkg::item_t pending_items[$];
    sched_result_t   expected_results[$];
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    int  hold_off_cycles = 0;
    int  hold_off_reqs = 0;
    int  hold_off_seen = 0;
    bit  sender_hold = 1'b0;
    bit  failed = 0;
    int  cycle_count = 0;

    // input handshake seen at the rising edge, used by the driver
    logic s_axis_tready_q = 1'b0;

    periodic_tick_compare_scheduler #(.EVENT_COUNT_BITS(ECB)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // seconds plus 32-bit fraction to counter ticks
    function automatic logic [63:0] ticks_of(input logic [16:0] sec, input logic [31:0] frac);
        logic [63:0] t;
        t = ({32'd0, freq_model} * {32'd0, frac}) >> 32;
        if (sec != 17'd0)
            t = t + {32'd0, freq_model} * {47'd0, sec};
        return t;
    endfunction

    // advance the shadow state by one item and build its result
    function automatic sched_result_t schedule_item(input ptcs_pkg::item_t it);
        sched_result_t r;
        logic [63:0] now, div, fdiv, base, delta, count, rem, inc, adj;
        r = '0;
        now = {1'b0, it.counter_now};
        if (it.op == ptcs_pkg::OP_START)
        begin
            div = it.period_given ? ticks_of(it.period_sec, it.period_frac) : 64'd0;
            fdiv = it.first_given ? ticks_of(it.first_sec, it.first_frac) : div;
            base = now;
            period_model = div;
            if (div != 64'd0)
            begin
                adjust_model = '0;
                base = ((base + div - 64'd1) / div) * div;
            end
            ref_model = base;
            r.compare_valid = 1'b1;
            r.compare_value = base + fdiv;
        end
        else if (it.op == ptcs_pkg::OP_IRQ)
        begin
            if (period_model != 64'd0)
            begin
                inc = period_model;
                adj = adjust_model;
                delta = now - ref_model;
                count = '0;
                rem = '0;
                r.compare_valid = 1'b1;
                r.compare_value = now + inc - adj;
                if (!delta[63])
                begin
                    count = delta / inc;
                    rem = delta % inc;
                end
                ref_model = ref_model + count * inc;
                if (adj != 64'd0)
                    adjusted_model = adjusted_model + count[31:0];
                if (count > 64'd0)
                begin
                    missed_model = missed_model + (count[31:0] - 32'd1);
                    if (rem > (inc >> 3))
                    begin
                        if (adj == 64'd0)
                            edges_model = edges_model + 32'd1;
                        adj = inc >> 4;
                    end
                    else
                        adj = '0;
                end
                else
                begin
                    adj = '0;
                    excess_model = excess_model + 32'd1;
                end
                adjust_model = adj;
                r.event_count = (count > 64'hFFFF) ? 16'hFFFF : count[15:0];
            end
            else
                r.event_count = 16'd1;
        end
        else if (it.op == ptcs_pkg::OP_STOP)
        begin
            period_model = '0;
            r.compare_valid = 1'b1;
            r.compare_value = ptcs_pkg::STOP_COMPARE;
        end
        r.edges_total = edges_model;
        r.excess_total = excess_model;
        r.missed_total = missed_model;
        r.adjusted_total = adjusted_model;
        return r;
    endfunction

    // driver: one transfer per accepted item, changes at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready_q)
                void'(pending_items.pop_front());
            if (s_axis_tvalid && !s_axis_tready_q)
                ; // hold the offered item
            else if (!sender_hold && pending_items.size() != 0 &&
                     $urandom_range(99) >= sender_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(ptcs_pkg::IN_TDATA_W - ptcs_pkg::IN_BITS){1'b0}},
                                 pending_items[0]};
            end
            else
                s_axis_tvalid <= 1'b0;
            m_axis_tready <= (hold_off_cycles == 0) &&
                             ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(schedule_item(
                ptcs_pkg::item_t'(s_axis_tdata[ptcs_pkg::IN_BITS-1:0])));
    end

    // long receiver hold-off counted on its own
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_reqs)
        begin
            hold_off_seen <= hold_off_reqs;
            hold_off_cycles <= 2000;
        end
        else if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = sched_result_t'(m_axis_tdata[193+ECB-1:0]);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                failed = 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.compare_valid !== want.compare_valid ||
                    got.compare_value !== want.compare_value ||
                    got.event_count !== want.event_count ||
                    got.edges_total !== want.edges_total ||
                    got.excess_total !== want.excess_total ||
                    got.missed_total !== want.missed_total ||
                    got.adjusted_total !== want.adjusted_total)
                begin
                    $display("%0t: expected %h actual %h", $realtime, want, got);
                    failed = 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random start, mostly small periods so interrupts catch a few periods
    function automatic ptcs_pkg::item_t random_start();
        ptcs_pkg::item_t it;
        logic [191:0] bits;
        bits = {rand64(), rand64(), rand64()};
        it = bits[ptcs_pkg::IN_BITS-1:0];
        it.op = ptcs_pkg::OP_START;
        it.counter_now = 63'(rand64());
        if ($urandom_range(3) != 0)
            it.counter_now = 63'($urandom_range(1000000));
        it.period_given = $urandom_range(5) != 0;
        it.first_given = 1'($urandom_range(1));
        it.period_sec = ($urandom_range(9) == 0) ? 17'($urandom_range(86400)) :
                        17'($urandom_range(2));
        it.first_sec = ($urandom_range(9) == 0) ? 17'($urandom_range(86400)) :
                       17'($urandom_range(2));
        it.period_frac = $urandom();
        it.first_frac = $urandom();
        return it;
    endfunction

    ptcs_pkg::item_t scratch;
    logic [62:0] clock_now;

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_frequency(input logic [31:0] f);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= f;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        freq_model = f;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one timer run: start then a chain of interrupts at random offsets, sometimes followed by a stop and an unused op
    task automatic queue_run(input int irqs);
        logic [191:0] bits;
        scratch = random_start();
        pending_items.push_back(scratch);
        clock_now = scratch.counter_now;
        for (int k = 0; k < irqs; k++)
        begin
            scratch = '0;
            scratch.op = ptcs_pkg::OP_IRQ;
            clock_now = clock_now + ($urandom_range(7) == 0 ? 63'(rand64()) :
                        63'($urandom_range(3 * freq_model + 10)));
            if ($urandom_range(15) == 0)
                clock_now = clock_now - 63'($urandom_range(1000));
            scratch.counter_now = clock_now;
            pending_items.push_back(scratch);
        end
        if ($urandom_range(3) == 0)
        begin
            bits = {rand64(), rand64(), rand64()};
            scratch = bits[ptcs_pkg::IN_BITS-1:0];
            scratch.op = ptcs_pkg::OP_STOP;
            pending_items.push_back(scratch);
        end
        if ($urandom_range(19) == 0)
        begin
            bits = {rand64(), rand64(), rand64()};
            scratch = bits[ptcs_pkg::IN_BITS-1:0];
            scratch.op = ptcs_pkg::OP_UNUSED;
            pending_items.push_back(scratch);
        end
    endtask

    logic [31:0] freq_list[6] = '{32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd12345, 32'd65536};

    initial
    begin
        freq_model = 32'd1;
        period_model = '0;
        adjust_model = '0;
        ref_model = '0;
        edges_model = '0;
        excess_model = '0;
        missed_model = '0;
        adjusted_model = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: interrupt with no timer, stop, unused op, field extremes
        scratch = '0; scratch.op = ptcs_pkg::OP_IRQ; pending_items.push_back(scratch);
        scratch = '0; scratch.op = ptcs_pkg::OP_STOP; pending_items.push_back(scratch);
        scratch = '1; scratch.op = ptcs_pkg::OP_UNUSED; pending_items.push_back(scratch);
        scratch = '0; scratch.op = ptcs_pkg::OP_START; scratch.counter_now = 63'd10;
        scratch.period_given = 1'b1; scratch.period_sec = 17'd4;
        pending_items.push_back(scratch);
        scratch = '0; scratch.op = ptcs_pkg::OP_IRQ; scratch.counter_now = 63'd13;
        pending_items.push_back(scratch);
        scratch.counter_now = 63'd19; pending_items.push_back(scratch);
        scratch.counter_now = 63'd2; pending_items.push_back(scratch);
        scratch.counter_now = 63'd300000; pending_items.push_back(scratch);
        scratch.counter_now = '1; pending_items.push_back(scratch);
        scratch = '1; scratch.op = ptcs_pkg::OP_START; scratch.period_sec = 17'd86400;
        scratch.first_sec = 17'd86400; pending_items.push_back(scratch);
        scratch = '0; scratch.op = ptcs_pkg::OP_START; scratch.counter_now = 63'd77;
        scratch.first_given = 1'b1; scratch.first_frac = '1;
        pending_items.push_back(scratch);
        scratch = '0; scratch.op = ptcs_pkg::OP_IRQ; pending_items.push_back(scratch);
        wait_drained();

        foreach (freq_list[p])
        begin
            write_frequency(freq_list[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 57; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 57; end
                default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            endcase
            if (p == 2)
                hold_off_reqs = hold_off_reqs + 1;
            while (pending_items.size() < 300)
                queue_run($urandom_range(12));
            if (p == 4)
            begin
                while (pending_items.size() > 150)
                    @(posedge clk);
                // sender pauses until everything outstanding has come back
                sender_hold = 1'b1;
                while (expected_results.size() != 0 || s_axis_tvalid)
                    @(posedge clk);
                repeat (20) @(posedge clk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
